// ===== rtl/rle_xor_chain_byte_encoder_unit_macros.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef RLE_XOR_CHAIN_BYTE_ENCODER_UNIT_MACROS_SVH
`define RLE_XOR_CHAIN_BYTE_ENCODER_UNIT_MACROS_SVH

// Check that cond holds in the same cycle as trig.
`define RXE_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that cond holds in the cycle after trig.
`define RXE_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== rtl/rxe_pkg.sv =====
// Shared types and constants of the run-length XOR chain encoder.
`default_nettype none

package rxe_pkg;

  // Input modes
  localparam logic [2:0] MODE_RAW       = 3'd0;
  localparam logic [2:0] MODE_CELL      = 3'd1;
  localparam logic [2:0] MODE_FLUSH     = 3'd2;
  localparam logic [2:0] MODE_CHAIN_CLR = 3'd3;
  localparam logic [2:0] MODE_CLR_SUMS  = 3'd4;
  localparam logic [2:0] MODE_EMIT_SUMS = 3'd5;

  // Back-end operations carried by the command queue
  localparam logic [1:0] OP_PUT1 = 2'd0;  // one byte
  localparam logic [1:0] OP_PUT2 = 2'd1;  // run pair: count then value
  localparam logic [1:0] OP_CLR  = 2'd2;  // clear both sums, no output
  localparam logic [1:0] OP_SUMS = 2'd3;  // eight sum bytes

  localparam logic [7:0] CELL_MASK_RESET = 8'hFF;

  localparam int unsigned RUN_LIMIT_DEFAULT   = 255;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  typedef struct packed {
    logic [1:0] op;
    logic       clr_chain;
    logic [7:0] b0;
    logic [7:0] b1;
  } rxe_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/rxe_front.sv =====
// Front end: takes input requests, tracks the current run and issues commands.
`default_nettype none

module rxe_front #(
  parameter int unsigned RUN_LIMIT = rxe_pkg::RUN_LIMIT_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [2:0]       in_mode,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             cfg_valid,
  input  wire logic [7:0]       cfg_data,
  input  wire logic             q_full,
  output logic                  q_push,
  output rxe_pkg::rxe_cmd_t     q_cmd
);

  localparam logic [7:0] RunLimitB = 8'(RUN_LIMIT);

  logic [7:0] cell_mask_r;
  logic [7:0] run_len_r, run_len_nxt;
  logic [7:0] run_val_r, run_val_nxt;
  logic [7:0] masked;
  logic       accept;
  logic       cmd_en;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign masked   = in_data_byte & cell_mask_r;
  assign q_push   = accept && cmd_en;

  always_comb begin
    cmd_en          = 1'b0;
    q_cmd.op        = rxe_pkg::OP_PUT1;
    q_cmd.clr_chain = 1'b0;
    q_cmd.b0        = in_data_byte;
    q_cmd.b1        = run_val_r;
    run_len_nxt     = run_len_r;
    run_val_nxt     = run_val_r;
    case (in_mode)
      rxe_pkg::MODE_RAW: begin
        cmd_en = 1'b1;
      end
      rxe_pkg::MODE_CHAIN_CLR: begin
        cmd_en          = 1'b1;
        q_cmd.clr_chain = 1'b1;
      end
      rxe_pkg::MODE_CELL: begin
        if (masked != run_val_r || run_len_r >= RunLimitB) begin
          // close the current run and open a new one
          cmd_en      = 1'b1;
          q_cmd.op    = rxe_pkg::OP_PUT2;
          q_cmd.b0    = run_len_r;
          run_len_nxt = 8'd1;
          run_val_nxt = masked;
        end else begin
          run_len_nxt = run_len_r + 8'd1;
        end
      end
      rxe_pkg::MODE_FLUSH: begin
        if (run_len_r != 8'd0) begin
          cmd_en   = 1'b1;
          q_cmd.op = rxe_pkg::OP_PUT2;
          q_cmd.b0 = run_len_r;
        end
        run_len_nxt = 8'd0;
        run_val_nxt = 8'd0;
      end
      rxe_pkg::MODE_CLR_SUMS: begin
        cmd_en   = 1'b1;
        q_cmd.op = rxe_pkg::OP_CLR;
      end
      rxe_pkg::MODE_EMIT_SUMS: begin
        cmd_en   = 1'b1;
        q_cmd.op = rxe_pkg::OP_SUMS;
      end
      default: begin
        cmd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_mask_r <= rxe_pkg::CELL_MASK_RESET;
      run_len_r   <= 8'd0;
      run_val_r   <= 8'd0;
    end else begin
      if (cfg_valid) begin
        cell_mask_r <= cfg_data;
      end
      if (accept) begin
        run_len_r <= run_len_nxt;
        run_val_r <= run_val_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rxe_queue.sv =====
// Command queue between the front end and the put stage.
`default_nettype none
`include "rle_xor_chain_byte_encoder_unit_macros.svh"

module rxe_queue #(
  parameter int unsigned DEPTH = rxe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire rxe_pkg::rxe_cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   head_valid,
  output rxe_pkg::rxe_cmd_t      head_cmd
);

  localparam int unsigned PtrW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CountW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0]   PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CountW-1:0] CountFull = CountW'(DEPTH);

  rxe_pkg::rxe_cmd_t slot_r [DEPTH];
  logic [PtrW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CountW-1:0] count_r, count_nxt;

  assign full       = (count_r == CountFull);
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + CountW'(1);
      2'b01:   count_nxt = count_r - CountW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + PtrW'(1);
      end
    end
  end

  `RXE_ASSERT_SAME(a_no_overflow, clk, rst_n, push, !full, "push into full queue")
  `RXE_ASSERT_SAME(a_no_underflow, clk, rst_n, pop, head_valid, "pop from empty queue")
  `RXE_ASSERT_SAME(a_count_range, clk, rst_n, 1'b1, count_r <= CountFull, "queue count overrun")

endmodule

`default_nettype wire

// ===== rtl/rxe_back.sv =====
// Put stage: XOR chain, running sums, sum emission and the output register.
`default_nettype none
`include "rle_xor_chain_byte_encoder_unit_macros.svh"

module rxe_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  wire rxe_pkg::rxe_cmd_t head_cmd,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_last_of_run,
  output logic [31:0]            out_plain_sum,
  output logic [31:0]            out_coded_sum
);

  logic [7:0]  chain_r, chain_nxt;
  logic [31:0] plain_r, plain_nxt;
  logic [31:0] coded_r, coded_nxt;
  logic [31:0] word_r, src_word;
  logic [2:0]  step_r, last_step;
  logic [7:0]  put_val, sum_byte, chain_in;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic [31:0] out_plain_r, out_coded_r;
  logic        is_clr, advance, step_done;

  always_comb begin
    case (head_cmd.op)
      rxe_pkg::OP_PUT2: last_step = 3'd1;
      rxe_pkg::OP_SUMS: last_step = 3'd7;
      default:          last_step = 3'd0;
    endcase
  end

  // first byte of each word comes from the live sum, the rest from the snapshot
  assign src_word = (step_r[1:0] == 2'd0) ? (step_r[2] ? coded_r : plain_r) : word_r;

  always_comb begin
    case (step_r[1:0])
      2'd0:    sum_byte = src_word[7:0];
      2'd1:    sum_byte = src_word[15:8];
      2'd2:    sum_byte = src_word[23:16];
      default: sum_byte = src_word[31:24];
    endcase
  end

  always_comb begin
    case (head_cmd.op)
      rxe_pkg::OP_PUT2: put_val = step_r[0] ? head_cmd.b1 : head_cmd.b0;
      rxe_pkg::OP_SUMS: put_val = sum_byte;
      default:          put_val = head_cmd.b0;
    endcase
  end

  assign chain_in  = (head_cmd.op == rxe_pkg::OP_PUT1 && head_cmd.clr_chain) ? 8'd0 : chain_r;
  assign chain_nxt = chain_in ^ put_val;
  assign plain_nxt = plain_r + {24'd0, put_val};
  assign coded_nxt = coded_r + {24'd0, chain_nxt};

  assign is_clr    = head_valid && (head_cmd.op == rxe_pkg::OP_CLR);
  assign advance   = head_valid && !is_clr && (!out_valid_r || out_ready);
  assign step_done = (step_r == last_step);
  assign pop       = is_clr || (advance && step_done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r     <= 8'd0;
      plain_r     <= 32'd0;
      coded_r     <= 32'd0;
      step_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        chain_r     <= chain_nxt;
        plain_r     <= plain_nxt;
        coded_r     <= coded_nxt;
        step_r      <= step_done ? 3'd0 : step_r + 3'd1;
        out_valid_r <= 1'b1;
      end else begin
        if (is_clr) begin
          plain_r <= 32'd0;
          coded_r <= 32'd0;
        end
        if (out_ready) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r  <= chain_nxt;
      out_last_r  <= step_done;
      out_plain_r <= plain_nxt;
      out_coded_r <= coded_nxt;
      if (step_r[1:0] == 2'd0) begin
        word_r <= src_word;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;
  assign out_plain_sum   = out_plain_r;
  assign out_coded_sum   = out_coded_r;

  `RXE_ASSERT_SAME(a_step_holds_cmd, clk, rst_n, step_r != 3'd0, head_valid, "mid-sequence without command")
  `RXE_ASSERT_SAME(a_step_range, clk, rst_n, head_valid, step_r <= last_step, "step past last byte")
  `RXE_ASSERT_NEXT(a_sums_last, clk, rst_n, advance && head_cmd.op == rxe_pkg::OP_SUMS && step_r == 3'd7, out_valid && out_last_of_run, "sum emission not closed")

endmodule

`default_nettype wire

// ===== rtl/rle_xor_chain_byte_encoder_unit.sv =====
// Top level of the run-length XOR chain byte encoder.
// Byte encoder with a run-length front end. Each input request carries a mode and a byte:
// raw bytes and chain-clear raw bytes give one result, run cells are masked with cell_mask and
// give a (count, value) pair of results when the run breaks or reaches RUN_LIMIT, a flush
// gives the pending pair (if any) and resets the run, clear-sums gives nothing, and emit-sums
// gives eight results (plain sum then coded sum, little-endian). Every result byte is the
// plain byte XORed into a running chain byte; each result also carries both 32-bit wrapping
// sums after that byte, and last_of_run marks the final result of a request. Input requests are
// accepted one per cycle while the command queue (QUEUE_DEPTH entries) has room; the put stage
// delivers one result byte per cycle while out_ready allows, so a run pair holds it for two bytes
// and a sum emission for eight, and long bursts of those stall the input once the queue fills.
// cell_mask is written through the cfg port, which is always ready; write it only while the
// block is idle.
`default_nettype none

module rle_xor_chain_byte_encoder_unit #(
  parameter int unsigned RUN_LIMIT   = rxe_pkg::RUN_LIMIT_DEFAULT,
  parameter int unsigned QUEUE_DEPTH = rxe_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input requests
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_data_byte,
  // results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run,
  output logic [31:0]      out_plain_sum,
  output logic [31:0]      out_coded_sum,
  // cell_mask write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  rxe_pkg::rxe_cmd_t push_cmd, head_cmd;
  logic              q_push, q_full, q_pop, q_head_valid;

  assign cfg_ready = 1'b1;

  // front: classify requests and track the run
  rxe_front #(
    .RUN_LIMIT (RUN_LIMIT)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  // decouple front and put stage
  rxe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (head_cmd)
  );

  // back: put bytes through the chain and sums, hold results until taken
  rxe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_cmd        (head_cmd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_plain_sum   (out_plain_sum),
    .out_coded_sum   (out_coded_sum)
  );

endmodule

`default_nettype wire

// ===== sim/rle_xor_chain_byte_encoder_unit_tb.sv =====
// Testbench for the run-length XOR chain byte encoder: directed table, random phases, predictor.
`timescale 1ns / 100ps

module rle_xor_chain_byte_encoder_unit_tb;

  // Modes the block must ignore
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  localparam int unsigned RUN_CAP       = rxe_pkg::RUN_LIMIT_DEFAULT;
  localparam int          SETTLE_CYCLES = 40;   // covers a full queue of sum bursts, with margin
  localparam int          HOLD_CYCLES   = 120;  // long receiver hold-off
  localparam logic [72:0] NO_PIN        = '0;

  // One result byte as it leaves the block
  typedef struct packed {
    logic [7:0]  code_byte;
    logic        last;
    logic [31:0] plain;
    logic [31:0] coded;
  } enc_result_t;

  // One row of the directed table; pinned rows carry a hand-computed single result
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  data;
    logic        pinned;
    logic [7:0]  pin_byte;
    logic [31:0] pin_plain;
    logic [31:0] pin_coded;
  } dir_row_t;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [2:0]  in_mode      = '0;
  logic [7:0]  in_data_byte = '0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_run;
  logic [31:0] out_plain_sum;
  logic [31:0] out_coded_sum;
  logic        cfg_valid    = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data     = '0;

  // Pinned expectation travels with the request, updated on the same edges as the payload
  logic        pin_on    = 1'b0;
  logic [7:0]  pin_byte  = '0;
  logic [31:0] pin_plain = '0;
  logic [31:0] pin_coded = '0;

  // Encoder image: chain, both sums, the open run and the cell mask
  logic [7:0]  chain_q     = '0;
  logic [31:0] plain_acc   = '0;
  logic [31:0] coded_acc   = '0;
  logic [7:0]  run_count   = '0;
  logic [7:0]  run_val     = '0;
  logic [7:0]  mask_shadow = rxe_pkg::CELL_MASK_RESET;

  enc_result_t step_out [0:7];
  int          step_n;
  enc_result_t expected_bytes [$];
  int          mismatch_count = 0;

  // Receiver pacing
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [3:0]  pat_idx       = '0;
  int          hold_req      = 0;
  int          hold_ack      = 0;
  int          hold_left     = 0;

  logic [7:0]  last_cell = '0;
  dir_row_t    dir_rows [0:23];

  rle_xor_chain_byte_encoder_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run),
    .out_plain_sum   (out_plain_sum),
    .out_coded_sum   (out_coded_sum),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Pass one plain byte through the chain and record the resulting output byte.
  task automatic put_through_chain(input logic [7:0] b, input logic last);
    chain_q   = chain_q ^ b;
    plain_acc = plain_acc + 32'(b);
    coded_acc = coded_acc + 32'(chain_q);
    step_out[step_n] = {chain_q, last, plain_acc, coded_acc};
    step_n++;
  endtask

  // Work out every result byte one request causes, advancing the encoder image.
  task automatic encode_request(input logic [2:0] m, input logic [7:0] d);
    logic [7:0]  masked;
    logic [31:0] word;
    int          i;
    step_n = 0;
    case (m)
      rxe_pkg::MODE_RAW: begin
        put_through_chain(d, 1'b1);
      end
      rxe_pkg::MODE_CHAIN_CLR: begin
        chain_q = '0;
        put_through_chain(d, 1'b1);
      end
      rxe_pkg::MODE_CELL: begin
        masked = d & mask_shadow;
        // Close the run on a new value or at the cap; the first run of a plane is (0, 0)
        if (masked != run_val || run_count >= RUN_CAP) begin
          put_through_chain(run_count, 1'b0);
          put_through_chain(run_val, 1'b1);
          run_val   = masked;
          run_count = 8'd1;
        end else begin
          run_count = run_count + 8'd1;
        end
      end
      rxe_pkg::MODE_FLUSH: begin
        // An empty run flushes silently, but the run always restarts at (0, 0)
        if (run_count != 0) begin
          put_through_chain(run_count, 1'b0);
          put_through_chain(run_val, 1'b1);
        end
        run_count = '0;
        run_val   = '0;
      end
      rxe_pkg::MODE_CLR_SUMS: begin
        plain_acc = '0;
        coded_acc = '0;
      end
      rxe_pkg::MODE_EMIT_SUMS: begin
        // Plain sum is taken up front; coded sum already includes the first four bytes
        word = plain_acc;
        for (i = 0; i < 4; i++) put_through_chain(word[8*i +: 8], 1'b0);
        word = coded_acc;
        for (i = 0; i < 4; i++) put_through_chain(word[8*i +: 8], i == 3);
      end
      default: begin
      end
    endcase
  endtask

  // Sample all three channels on the same edge: predict on request, check on result.
  always @(posedge clk) begin : watch
    enc_result_t got;
    enc_result_t want;
    int          k;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        encode_request(in_mode, in_data_byte);
        if (pin_on) begin
          step_n      = 1;
          step_out[0] = {pin_byte, 1'b1, pin_plain, pin_coded};
        end
        for (k = 0; k < step_n; k++) expected_bytes.push_back(step_out[k]);
      end
      if (out_valid && out_ready) begin
        got = {out_byte, out_last_of_run, out_plain_sum, out_coded_sum};
        if (expected_bytes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("MISMATCH at %0t: result byte %02h with nothing pending", $time, out_byte);
        end else begin
          want = expected_bytes.pop_front();
          if (got.code_byte !== want.code_byte || got.last !== want.last ||
              got.plain !== want.plain || got.coded !== want.coded) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("MISMATCH at %0t (expected/actual): byte %02h/%02h last %0d/%0d",
                       $time, want.code_byte, got.code_byte, want.last, got.last);
              $display("  plain %08h/%08h coded %08h/%08h",
                       want.plain, got.plain, want.coded, got.coded);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) mask_shadow = cfg_data;
    end
  end

  // Receiver: follow the rotating ready pattern, or hold off when asked.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ready_pattern[pat_idx];
      pat_idx   <= pat_idx + 4'd1;
    end
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(input logic [2:0] m, input logic [7:0] d, input logic pin,
                              input logic [7:0] pb, input logic [31:0] pp,
                              input logic [31:0] pc);
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_data_byte <= d;
    pin_on       <= pin;
    pin_byte     <= pb;
    pin_plain    <= pp;
    pin_coded    <= pc;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, wait out every pending result, then let the back end settle.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write cell_mask; only called while idle.
  task automatic set_cell_mask(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Pick a random request; cells mostly continue the current run under the mask.
  task automatic pick_request(output logic [2:0] m, output logic [7:0] d);
    int roll;
    roll = $urandom_range(0, 99);
    d    = 8'($urandom);
    if (roll < 50) begin
      m = rxe_pkg::MODE_CELL;
      if ($urandom_range(0, 9) < 6) d = (last_cell & mask_shadow) | (8'($urandom) & ~mask_shadow);
      last_cell = d;
    end else if (roll < 65) m = rxe_pkg::MODE_RAW;
    else if (roll < 73) m = rxe_pkg::MODE_CHAIN_CLR;
    else if (roll < 83) m = rxe_pkg::MODE_FLUSH;
    else if (roll < 88) m = rxe_pkg::MODE_CLR_SUMS;
    else if (roll < 96) m = rxe_pkg::MODE_EMIT_SUMS;
    else m = $urandom_range(0, 1) ? MODE_SPARE6 : MODE_SPARE7;
  endtask

  // Send random requests in bursts separated by random gaps.
  task automatic run_random(input int count, input int max_gap, input int max_burst);
    int         burst_left;
    int         gap;
    int         n;
    logic [2:0] m;
    logic [7:0] d;
    burst_left = 0;
    for (n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, max_burst);
      end
      pick_request(m, d);
      send_request(m, d, 1'b0, 8'h00, 32'd0, 32'd0);
      burst_left--;
    end
  endtask

  initial begin
    int i;
    // Pinned rows start from reset state with the reset mask
    dir_rows[0]  = {rxe_pkg::MODE_RAW,       8'hFF, 1'b1, 8'hFF, 32'd255, 32'd255};
    dir_rows[1]  = {rxe_pkg::MODE_CHAIN_CLR, 8'h00, 1'b1, 8'h00, 32'd255, 32'd255};
    dir_rows[2]  = {rxe_pkg::MODE_RAW,       8'h80, 1'b1, 8'h80, 32'd383, 32'd383};
    dir_rows[3]  = {rxe_pkg::MODE_CLR_SUMS,  8'hA5, NO_PIN};
    dir_rows[4]  = {rxe_pkg::MODE_RAW,       8'h01, 1'b1, 8'h81, 32'd1,   32'd129};
    dir_rows[5]  = {rxe_pkg::MODE_CHAIN_CLR, 8'hFF, 1'b1, 8'hFF, 32'd256, 32'd384};
    // Run of zeros continues the initial (0, 0) run, then a new value breaks it
    dir_rows[6]  = {rxe_pkg::MODE_CELL,      8'h00, NO_PIN};
    dir_rows[7]  = {rxe_pkg::MODE_CELL,      8'h00, NO_PIN};
    dir_rows[8]  = {rxe_pkg::MODE_CELL,      8'h5A, NO_PIN};
    dir_rows[9]  = {rxe_pkg::MODE_CELL,      8'h5A, NO_PIN};
    dir_rows[10] = {rxe_pkg::MODE_FLUSH,     8'h00, NO_PIN};
    // Empty flush, then a first cell that differs from zero emits the (0, 0) pair
    dir_rows[11] = {rxe_pkg::MODE_FLUSH,     8'hFF, NO_PIN};
    dir_rows[12] = {rxe_pkg::MODE_CELL,      8'hFF, NO_PIN};
    dir_rows[13] = {rxe_pkg::MODE_CELL,      8'hFF, NO_PIN};
    dir_rows[14] = {rxe_pkg::MODE_CELL,      8'h7F, NO_PIN};
    dir_rows[15] = {MODE_SPARE6,             8'hFF, NO_PIN};
    dir_rows[16] = {MODE_SPARE7,             8'h00, NO_PIN};
    dir_rows[17] = {rxe_pkg::MODE_EMIT_SUMS, 8'hFF, NO_PIN};
    dir_rows[18] = {rxe_pkg::MODE_FLUSH,     8'h00, NO_PIN};
    dir_rows[19] = {rxe_pkg::MODE_RAW,       8'h00, NO_PIN};
    dir_rows[20] = {rxe_pkg::MODE_CLR_SUMS,  8'h00, NO_PIN};
    dir_rows[21] = {rxe_pkg::MODE_EMIT_SUMS, 8'h00, NO_PIN};
    dir_rows[22] = {rxe_pkg::MODE_CELL,      8'h00, NO_PIN};
    dir_rows[23] = {rxe_pkg::MODE_FLUSH,     8'h00, NO_PIN};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under the reset mask
    ready_pattern <= 16'($urandom) | 16'h0001;
    for (i = 0; i < 24; i++)
      send_request(dir_rows[i].mode, dir_rows[i].data, dir_rows[i].pinned,
                   dir_rows[i].pin_byte, dir_rows[i].pin_plain, dir_rows[i].pin_coded);
    wait_for_idle();

    // Low-nibble mask; hold the receiver off so the queue fills and stalls the input
    set_cell_mask(8'h0F);
    ready_pattern <= 16'($urandom) | 16'h0001;
    hold_req      <= hold_req + 1;
    run_random(60, 3, 8);
    wait_for_idle();

    // Mask zero: every cell matches, so one long run reaches the cap; no idling anywhere
    set_cell_mask(8'h00);
    ready_pattern <= 16'hFFFF;
    send_request(rxe_pkg::MODE_FLUSH, 8'h00, 1'b0, 8'h00, 32'd0, 32'd0);
    for (i = 0; i < 260; i++)
      send_request(rxe_pkg::MODE_CELL, 8'($urandom), 1'b0, 8'h00, 32'd0, 32'd0);
    run_random(20, 0, 1);
    wait_for_idle();

    // Full mask with long sender gaps
    set_cell_mask(8'hFF);
    ready_pattern <= 16'($urandom) | 16'h0001;
    run_random(60, 6, 4);
    wait_for_idle();

    // Random mask, sparse receiver and another long hold-off
    set_cell_mask(8'($urandom_range(1, 254)));
    ready_pattern <= 16'($urandom & $urandom) | 16'h0001;
    hold_req      <= hold_req + 1;
    run_random(60, 2, 12);
    wait_for_idle();

    if (mismatch_count == 0 && expected_bytes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
